[rtl/crcbp_pkg.sv]
// Shared constants and types for the CRC codeword bit packer.
// No dependencies; used by the encoder, the packer and the top level.
`timescale 1ns / 1ps

package crcbp_pkg;

  // Default sizing of the generator and the message byte counter
  localparam int unsigned DEF_MAX_GENERATOR_BITS = 9;
  localparam int unsigned DEF_COUNT_WIDTH        = 24;

  // Field widths
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned GEN_BITS_W = 9;
  localparam int unsigned GEN_LEN_W  = 4;
  localparam int unsigned TOTAL_W    = 24;

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] CFG_GEN_BITS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GEN_LEN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_FOUR     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TOTAL    = 2'd3;

  // Register reset values
  localparam logic [GEN_BITS_W-1:0] RST_GEN_BITS = 9'd263;
  localparam logic [GEN_LEN_W-1:0]  RST_GEN_LEN  = 4'd9;
  localparam logic                  RST_FOUR     = 1'b0;
  localparam logic [TOTAL_W-1:0]    RST_TOTAL    = 24'd1;

  // Configuration as seen by the encoder
  typedef struct packed {
    logic [GEN_BITS_W-1:0] gen_bits;
    logic [GEN_LEN_W-1:0]  gen_len;
    logic                  four;
    logic [TOTAL_W-1:0]    total;
  } cfg_t;

  // Control of the encoded item passed from encoder to packer
  typedef struct packed {
    logic valid;
    logic last;
  } item_ctl_t;

endpackage

[rtl/crcbp_encoder.sv]
// Encoder stage: registers one encoded item per accepted input byte.
// Builds header, pad and CRC codewords left-aligned; depends on crcbp_pkg.
`timescale 1ns / 1ps

module crcbp_encoder #(
  parameter int unsigned MAX_GENERATOR_BITS = crcbp_pkg::DEF_MAX_GENERATOR_BITS,
  parameter int unsigned COUNT_WIDTH        = crcbp_pkg::DEF_COUNT_WIDTH,
  localparam int unsigned ITEM_W = 2 * MAX_GENERATOR_BITS + 22,
  localparam int unsigned ILW    = $clog2(ITEM_W + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  crcbp_pkg::cfg_t       cfg_i,
  input  logic                  data_valid_i,
  output logic                  data_stall_o,
  input  logic [7:0]            data_byte_i,
  output crcbp_pkg::item_ctl_t  item_o,
  input  logic                  item_take_i,
  output logic [ITEM_W-1:0]     item_bits_o,
  output logic [ILW-1:0]        item_len_o
);

  localparam int unsigned GW    = MAX_GENERATOR_BITS;
  localparam int unsigned GLW   = $clog2(MAX_GENERATOR_BITS + 1);
  localparam int unsigned GIW   = $clog2(MAX_GENERATOR_BITS);
  localparam int unsigned CMPW  = (GLW > crcbp_pkg::GEN_LEN_W) ? GLW : crcbp_pkg::GEN_LEN_W;
  localparam int unsigned CWW   = MAX_GENERATOR_BITS + 7;
  localparam int unsigned CWA_W = 2 * (MAX_GENERATOR_BITS + 3);

  // Long division of one dataword: window of g bits, one dataword bit a step
  function automatic logic [GW-1:0] crc_rem(
    input logic [7:0]     data,
    input logic           four,
    input logic [GW-1:0]  gen,
    input logic [GLW-1:0] g,
    input logic [GW-1:0]  gmask
  );
    logic [CWW-1:0] cw;
    logic [GW-1:0]  win;
    logic [2:0]     dm2;
    logic [2:0]     idx;
    logic           lead;
    cw   = CWW'(data) << (g - GLW'(1));
    win  = four ? GW'(cw >> 3) : GW'(cw >> 7);
    dm2  = four ? 3'd2 : 3'd6;
    for (int j = 0; j < 8; j++) begin
      if (j < 4 || !four) begin
        lead = win[GIW'(g - GLW'(1))];
        if (lead) begin
          win = win ^ gen;
        end
        if ((four && j < 3) || (!four && j < 7)) begin
          idx = dm2 - 3'(j);
          win = ((win << 1) & gmask) | GW'(cw[idx]);
        end
      end
    end
    return win & (gmask >> 1);
  endfunction

  logic                   item_valid_q, item_valid_d;
  logic                   item_last_q, item_last_d;
  logic [ITEM_W-1:0]      item_bits_q, item_bits_d;
  logic [ILW-1:0]         item_len_q, item_len_d;
  logic                   header_done_q, header_done_d;
  logic [COUNT_WIDTH-1:0] bytes_seen_q, bytes_seen_d;

  logic                   accept;
  logic [CMPW-1:0]        len_x;
  logic [GLW-1:0]         g;
  logic [GW-1:0]          gmask;
  logic [GW-1:0]          gen;
  logic [GW-1:0]          rem_a, rem_h, rem_l;
  logic [ILW-1:0]         wlen;
  logic [ILW-1:0]         lw;
  logic [CWA_W-1:0]       cw_hi, cw_lo, cw_all, cw_left;
  logic [ITEM_W-1:0]      word_ext;
  logic [COUNT_WIDTH-1:0] tot, tot_eff, bytes_next;
  logic [5:0]             prod;
  logic [3:0]             pad;
  logic                   stream_end;

  assign accept       = data_valid_i && !data_stall_o;
  assign data_stall_o = item_valid_q && !item_take_i;

  // Clamp the generator length and mask the generator
  always_comb begin
    len_x = CMPW'(cfg_i.gen_len);
    if (len_x == '0) begin
      g = GLW'(1);
    end else if (len_x > CMPW'(MAX_GENERATOR_BITS)) begin
      g = GLW'(MAX_GENERATOR_BITS);
    end else begin
      g = GLW'(len_x);
    end
    gmask = ~({GW{1'b1}} << g);
    gen   = GW'(cfg_i.gen_bits) & gmask;
  end

  // Remainders for the whole byte and for each nibble
  assign rem_a = crc_rem(data_byte_i, 1'b0, gen, g, gmask);
  assign rem_h = crc_rem({4'b0, data_byte_i[7:4]}, 1'b1, gen, g, gmask);
  assign rem_l = crc_rem({4'b0, data_byte_i[3:0]}, 1'b1, gen, g, gmask);

  // Assemble the codeword bits of this byte, then left-align them
  always_comb begin
    if (cfg_i.four) begin
      wlen = ILW'(4) + ILW'(g) - ILW'(1);
      lw   = wlen << 1;
    end else begin
      wlen = ILW'(8) + ILW'(g) - ILW'(1);
      lw   = wlen;
    end
    cw_hi = (CWA_W'(data_byte_i[7:4]) << (g - GLW'(1))) | CWA_W'(rem_h);
    cw_lo = (CWA_W'(data_byte_i[3:0]) << (g - GLW'(1))) | CWA_W'(rem_l);
    if (cfg_i.four) begin
      cw_all = (cw_hi << wlen) | cw_lo;
    end else begin
      cw_all = (CWA_W'(data_byte_i) << (g - GLW'(1))) | CWA_W'(rem_a);
    end
    cw_left  = cw_all << (ILW'(CWA_W) - lw);
    word_ext = {cw_left, 16'b0};
  end

  // Pad count from the configured message length
  always_comb begin
    tot     = COUNT_WIDTH'(cfg_i.total);
    tot_eff = (tot == '0) ? COUNT_WIDTH'(1) : tot;
    prod    = 6'(tot_eff[2:0]) * 6'(lw[2:0]);
    pad     = 4'd8 - {1'b0, prod[2:0]};
  end

  assign bytes_next = bytes_seen_q + COUNT_WIDTH'(1);
  assign stream_end = (bytes_next >= tot_eff);

  // Load the next item, release it once the packer takes it
  always_comb begin
    item_valid_d  = item_valid_q;
    item_last_d   = item_last_q;
    item_bits_d   = item_bits_q;
    item_len_d    = item_len_q;
    header_done_d = header_done_q;
    bytes_seen_d  = bytes_seen_q;
    if (item_take_i) begin
      item_valid_d = 1'b0;
    end
    if (accept) begin
      item_valid_d = 1'b1;
      item_last_d  = stream_end;
      if (!header_done_q) begin
        item_bits_d = {8'(pad), {(ITEM_W - 8){1'b0}}} | (word_ext >> (5'd8 + 5'(pad)));
        item_len_d  = ILW'(8) + ILW'(pad) + lw;
      end else begin
        item_bits_d = word_ext;
        item_len_d  = lw;
      end
      if (stream_end) begin
        header_done_d = 1'b0;
        bytes_seen_d  = '0;
      end else begin
        header_done_d = 1'b1;
        bytes_seen_d  = bytes_next;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_valid_q  <= 1'b0;
      item_last_q   <= 1'b0;
      header_done_q <= 1'b0;
      bytes_seen_q  <= '0;
    end else begin
      item_valid_q  <= item_valid_d;
      item_last_q   <= item_last_d;
      header_done_q <= header_done_d;
      bytes_seen_q  <= bytes_seen_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_bits_q <= item_bits_d;
    item_len_q  <= item_len_d;
  end

  assign item_o.valid = item_valid_q;
  assign item_o.last  = item_last_q;
  assign item_bits_o  = item_bits_q;
  assign item_len_o   = item_len_q;

endmodule

[rtl/crcbp_packer.sv]
// Bit packer, depends on crcbp_pkg: left-aligned bit buffer that merges
// encoded items and issues one output byte per cycle unless out_stall_i is high.
`timescale 1ns / 1ps

module crcbp_packer #(
  parameter int unsigned MAX_GENERATOR_BITS = crcbp_pkg::DEF_MAX_GENERATOR_BITS,
  localparam int unsigned ITEM_W = 2 * MAX_GENERATOR_BITS + 22,
  localparam int unsigned ILW    = $clog2(ITEM_W + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  crcbp_pkg::item_ctl_t item_i,
  input  logic [ITEM_W-1:0]    item_bits_i,
  input  logic [ILW-1:0]       item_len_i,
  output logic                 item_take_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [7:0]           out_byte_o,
  output logic                 last_o
);

  localparam int unsigned BUF_W = ITEM_W + 7;
  localparam int unsigned CNW   = $clog2(BUF_W + 1);

  logic [BUF_W-1:0] buf_q, buf_d, buf_pop;
  logic [CNW-1:0]   cnt_q, cnt_d, cnt_pop, cnt_sum;
  logic             end_q, end_d;
  logic             pop;

  assign out_valid_o = (cnt_q >= CNW'(8));
  assign out_byte_o  = buf_q[BUF_W-1 -: 8];
  assign last_o      = end_q && (cnt_q == CNW'(8));

  assign pop         = out_valid_o && !out_stall_i;
  assign cnt_pop     = pop ? (cnt_q - CNW'(8)) : cnt_q;
  assign buf_pop     = pop ? (buf_q << 8) : buf_q;
  // Take a new item once less than a byte is left behind
  assign item_take_o = item_i.valid && (cnt_pop < CNW'(8));
  assign cnt_sum     = cnt_pop + CNW'(item_len_i);

  // Merge the item behind the held bits; round the stream end up to a byte
  always_comb begin
    buf_d = buf_pop;
    cnt_d = cnt_pop;
    end_d = end_q && (cnt_pop != '0);
    if (item_take_o) begin
      buf_d = buf_pop | ({item_bits_i, 7'b0} >> cnt_pop[2:0]);
      end_d = item_i.last;
      if (item_i.last) begin
        cnt_d = (cnt_sum + CNW'(7)) & ~CNW'(7);
      end else begin
        cnt_d = cnt_sum;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      cnt_q <= '0;
      end_q <= 1'b0;
    end else begin
      buf_q <= buf_d;
      cnt_q <= cnt_d;
      end_q <= end_d;
    end
  end

endmodule

[rtl/crc_codeword_bit_packer_top.sv]
// CRC codeword bit packer, top level: configuration registers, encoder
// and bit packer. Depends on crcbp_pkg, crcbp_encoder and crcbp_packer.
//
// Each message byte becomes one 8-bit or two 4-bit datawords, each followed
// by its CRC remainder over a generator of up to MAX_GENERATOR_BITS bits.
// The stream opens with a header byte holding the pad count and that many
// zero bits; the final byte carries last_o, after which the next byte starts
// a new stream. The output port moves one byte per cycle unless out_stall_i
// is high or fewer than eight bits are held. The codeword length per byte is
// 8 + g - 1 bits for whole bytes or 2 * (4 + g - 1) for nibbles; the first
// byte of a stream adds the header byte and the pad bits. The encoder
// registers one item per cycle while its held item is empty or being taken,
// and the bit buffer takes it once fewer than eight bits remain. At the end of a
// stream the buffer drains before the next stream's first item is merged.
// Configuration writes are always ready and are registered before the encoder sees them.
`timescale 1ns / 1ps

module crc_codeword_bit_packer_top #(
  parameter int unsigned MAX_GENERATOR_BITS = crcbp_pkg::DEF_MAX_GENERATOR_BITS,
  parameter int unsigned COUNT_WIDTH        = crcbp_pkg::DEF_COUNT_WIDTH
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [crcbp_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [crcbp_pkg::CFG_DATA_W-1:0] cfg_data_i,
  // input bytes
  input  logic                            data_valid_i,
  output logic                            data_stall_o,
  input  logic [7:0]                      data_byte_i,
  // output bytes
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [7:0]                      out_byte_o,
  output logic                            last_o
);

  localparam int unsigned ITEM_W = 2 * MAX_GENERATOR_BITS + 22;
  localparam int unsigned ILW    = $clog2(ITEM_W + 1);

  crcbp_pkg::cfg_t      cfg_q, cfg_d;
  crcbp_pkg::item_ctl_t item;
  logic [ITEM_W-1:0]    item_bits;
  logic [ILW-1:0]       item_len;
  logic                 item_take;

  assign cfg_ready_o = 1'b1;

  // Write the addressed register
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        crcbp_pkg::CFG_GEN_BITS: cfg_d.gen_bits = cfg_data_i[crcbp_pkg::GEN_BITS_W-1:0];
        crcbp_pkg::CFG_GEN_LEN:  cfg_d.gen_len  = cfg_data_i[crcbp_pkg::GEN_LEN_W-1:0];
        crcbp_pkg::CFG_FOUR:     cfg_d.four     = cfg_data_i[0];
        crcbp_pkg::CFG_TOTAL:    cfg_d.total    = cfg_data_i[crcbp_pkg::TOTAL_W-1:0];
        default:                 cfg_d          = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gen_bits <= crcbp_pkg::RST_GEN_BITS;
      cfg_q.gen_len  <= crcbp_pkg::RST_GEN_LEN;
      cfg_q.four     <= crcbp_pkg::RST_FOUR;
      cfg_q.total    <= crcbp_pkg::RST_TOTAL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  crcbp_encoder #(
    .MAX_GENERATOR_BITS (MAX_GENERATOR_BITS),
    .COUNT_WIDTH        (COUNT_WIDTH)
  ) u_encoder (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .data_valid_i (data_valid_i),
    .data_stall_o (data_stall_o),
    .data_byte_i  (data_byte_i),
    .item_o       (item),
    .item_take_i  (item_take),
    .item_bits_o  (item_bits),
    .item_len_o   (item_len)
  );

  crcbp_packer #(
    .MAX_GENERATOR_BITS (MAX_GENERATOR_BITS)
  ) u_packer (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item),
    .item_bits_i (item_bits),
    .item_len_i  (item_len),
    .item_take_o (item_take),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_byte_o  (out_byte_o),
    .last_o      (last_o)
  );

endmodule
